[rtl/lfr_pkg.sv]
// Shared constants, opcodes and sequencer state codes for the LRU frame replacer.
package lfr_pkg;

  localparam int ID_W = 6;
  localparam int ID_SPACE = 2 ** ID_W;
  localparam int CAP_W = 7;
  localparam int COUNT_OUT_W = 7;
  localparam int NUM_FRAMES_DEF = 64;
  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_PIN = 2'd1;
  localparam logic [1:0] OP_UNPIN = 2'd2;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_READ   = 6'b000010,
    ST_CHECK  = 6'b000100,
    ST_SH_RD  = 6'b001000,
    ST_SH_WR  = 6'b010000,
    ST_FINISH = 6'b100000
  } seq_state_t;

endpackage

[rtl/lfr_order_mem.sv]
// Recency order storage: one write port and one registered read port.
module lfr_order_mem #(
  parameter int DEPTH = lfr_pkg::NUM_FRAMES_DEF
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(DEPTH)-1:0]     waddr,
  input  logic [lfr_pkg::ID_W-1:0]     wdata,
  input  logic [$clog2(DEPTH)-1:0]     raddr,
  output logic [lfr_pkg::ID_W-1:0]     rdata
);

  logic [lfr_pkg::ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/lru_frame_replacer_unit.sv]
// Top level of the LRU frame replacer: request sequencer, presence map and result register.
//
// The block keeps an ordered list of evictable frame ids, oldest first, in a small
// single-port-read memory, plus a presence bit per frame id in flip-flops. An unpin request
// appends a frame at the newest end, unless it is already present or the list already holds
// the configured capacity (capped at the frame count). A pin request removes a present frame;
// a victim request removes and returns the oldest frame. Each request produces exactly one
// result carrying the entry count after the request. Requests are handled one at a time by a
// sequencer that drives one compare unit and the memory's single read port. An unpin or an
// ignored request goes from the idle state straight to the finish state, which loads the
// result register. A pin or victim request first scans the list, one entry at a time through
// the read and check states, until it finds the frame, then closes the gap by moving every
// later entry down one slot through the shift read and shift write states, because every step
// waits for the registered read of the memory. A finished result waits in its own output
// register, so the next request can be accepted before the previous result is taken. The
// capacity register is written through its own port and should only change while the block
// is idle.
module lru_frame_replacer_unit #(
  parameter int NUM_FRAMES = lfr_pkg::NUM_FRAMES_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration write channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lfr_pkg::CAP_W-1:0]         capacity,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        opcode,
  input  logic [lfr_pkg::ID_W-1:0]          page_frame,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              victim_found,
  output logic [lfr_pkg::ID_W-1:0]          victim_frame,
  output logic [lfr_pkg::COUNT_OUT_W-1:0]   entry_count
);

  // Only ids that fit the frame field can ever be held, so storage stops there.
  localparam int PD = (NUM_FRAMES < lfr_pkg::ID_SPACE) ? NUM_FRAMES : lfr_pkg::ID_SPACE;
  localparam int AW = $clog2(PD);
  localparam int CW = $clog2(PD + 1);

  lfr_pkg::seq_state_t state;

  logic [CW-1:0]                 cnt;
  logic [PD-1:0]                 present;
  logic [lfr_pkg::CAP_W-1:0]     cap;
  logic [AW-1:0]                 ptr;
  logic [1:0]                    op_q;
  logic [lfr_pkg::ID_W-1:0]      tgt;
  logic                          found_q;

  logic [CW:0]                   ptr_nx;
  logic                          fid_ok;
  logic                          fid_present;
  logic                          unpin_ok;
  logic                          mem_we;
  logic [AW-1:0]                 mem_waddr;
  logic [lfr_pkg::ID_W-1:0]      mem_wdata;
  logic [AW-1:0]                 mem_raddr;
  logic [lfr_pkg::ID_W-1:0]      mem_rdata;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == lfr_pkg::ST_IDLE);

  assign ptr_nx      = (CW + 1)'(ptr) + (CW + 1)'(1);
  assign fid_ok      = int'(page_frame) < NUM_FRAMES;
  assign fid_present = fid_ok && present[page_frame[AW-1:0]];
  // An unpin is admitted only below both the configured capacity and the frame count.
  assign unpin_ok    = fid_ok && !fid_present &&
                       (lfr_pkg::CAP_W'(cnt) < cap) && (int'(cnt) < NUM_FRAMES);

  // The memory takes the appended id on an admitted unpin, or one moved entry per shift step.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr;
    mem_wdata = mem_rdata;
    if (state == lfr_pkg::ST_IDLE && in_valid && opcode == lfr_pkg::OP_UNPIN && unpin_ok) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(cnt);
      mem_wdata = page_frame;
    end else if (state == lfr_pkg::ST_SH_WR) begin
      mem_we    = 1'b1;
    end
  end

  // During the shift the entry one slot above the pointer is fetched.
  assign mem_raddr = (state == lfr_pkg::ST_SH_RD) ? AW'(ptr_nx) : ptr;

  lfr_order_mem #(
    .DEPTH (PD)
  ) u_order_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lfr_pkg::ST_IDLE;
      cnt       <= '0;
      present   <= '0;
      cap       <= lfr_pkg::CAP_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cap <= capacity;
      end
      // A result loaded in the finish state takes over the register in the same cycle.
      if (out_valid && out_ready && state != lfr_pkg::ST_FINISH) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        lfr_pkg::ST_IDLE: begin
          if (in_valid) begin
            op_q    <= opcode;
            tgt     <= page_frame;
            found_q <= 1'b0;
            ptr     <= '0;
            unique case (opcode)
              lfr_pkg::OP_VICTIM: begin
                if (cnt != '0) begin
                  state <= lfr_pkg::ST_READ;
                end else begin
                  state <= lfr_pkg::ST_FINISH;
                end
              end
              lfr_pkg::OP_PIN: begin
                if (fid_present) begin
                  state <= lfr_pkg::ST_READ;
                end else begin
                  state <= lfr_pkg::ST_FINISH;
                end
              end
              lfr_pkg::OP_UNPIN: begin
                state <= lfr_pkg::ST_FINISH;
                if (unpin_ok) begin
                  present[page_frame[AW-1:0]] <= 1'b1;
                  cnt <= cnt + CW'(1);
                end
              end
              default: begin
                state <= lfr_pkg::ST_FINISH;
              end
            endcase
          end
        end
        lfr_pkg::ST_READ: begin
          state <= lfr_pkg::ST_CHECK;
        end
        lfr_pkg::ST_CHECK: begin
          // The victim is always the oldest slot; a pin scans until its id matches.
          if (op_q == lfr_pkg::OP_VICTIM || mem_rdata == tgt) begin
            if (op_q == lfr_pkg::OP_VICTIM) begin
              tgt     <= mem_rdata;
              found_q <= 1'b1;
            end
            state <= lfr_pkg::ST_SH_RD;
          end else begin
            ptr   <= AW'(ptr_nx);
            state <= lfr_pkg::ST_READ;
          end
        end
        lfr_pkg::ST_SH_RD: begin
          if (ptr_nx < (CW + 1)'(cnt)) begin
            state <= lfr_pkg::ST_SH_WR;
          end else begin
            cnt                  <= cnt - CW'(1);
            present[tgt[AW-1:0]] <= 1'b0;
            state                <= lfr_pkg::ST_FINISH;
          end
        end
        lfr_pkg::ST_SH_WR: begin
          ptr   <= AW'(ptr_nx);
          state <= lfr_pkg::ST_SH_RD;
        end
        lfr_pkg::ST_FINISH: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            victim_found <= found_q;
            victim_frame <= found_q ? tgt : '0;
            entry_count  <= lfr_pkg::COUNT_OUT_W'(cnt);
            state        <= lfr_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= lfr_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // The presence map and the entry count always describe the same set.
  a_count_matches_map: assert property (@(posedge clk) disable iff (rst)
    $countones(present) == int'(cnt))
    else $error("presence map population differs from entry count");

  // A scan or a victim read never looks past the last held slot.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == lfr_pkg::ST_CHECK) |-> (int'(ptr) < int'(cnt)))
    else $error("scan pointer ran past the held entries");

  // A finished request whose result register is free shows its result next cycle.
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == lfr_pkg::ST_FINISH && (!out_valid || out_ready)) |=>
      (out_valid && state == lfr_pkg::ST_IDLE))
    else $error("finished request did not reach the result register");

endmodule

[tb/sv/tb_lru_frame_replacer_unit.sv]
// Self-checking testbench for the LRU frame replacer: directed and random requests against a predictor.
module tb_lru_frame_replacer_unit;

  // The opcode field is two bits wide, so one code is left unassigned. The block must treat
  // it as a no-op that still returns a reply.
  localparam logic [1:0] OP_RESERVED = 2'd3;

  localparam int NUM_FRAMES    = lfr_pkg::NUM_FRAMES_DEF;
  localparam int RUN_REQUESTS  = 925;      // directed requests plus about 900 random ones
  localparam int CYCLE_LIMIT   = 1500000;  // several times the slowest legal run
  localparam int SETTLE_CYCLES = 200;      // longer than a pin or victim on a full list
  localparam int REPORT_MAX    = 10;

  // What the stimulus script holds: a request, a capacity write, or a pause that waits until
  // every outstanding reply has been taken.
  typedef enum logic [1:0] {
    STEP_REQUEST,
    STEP_CAPACITY,
    STEP_QUIESCE
  } step_kind_t;

  typedef struct packed {
    step_kind_t                      kind;
    logic [1:0]                      op;
    logic [lfr_pkg::ID_W-1:0]        fid;
    logic [lfr_pkg::CAP_W-1:0]       cap;
  } script_step_t;

  typedef struct packed {
    logic                            found;
    logic [lfr_pkg::ID_W-1:0]        frame;
    logic [lfr_pkg::COUNT_OUT_W-1:0] count;
  } replacer_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lfr_pkg::CAP_W-1:0]       capacity = '0;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  logic [1:0]                      opcode = '0;
  logic [lfr_pkg::ID_W-1:0]        page_frame = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  logic                            victim_found;
  logic [lfr_pkg::ID_W-1:0]        victim_frame;
  logic [lfr_pkg::COUNT_OUT_W-1:0] entry_count;

  // Stimulus script, filled once at time zero and consumed by the request driver.
  script_step_t    request_script[$];
  // Replies that the predictor has worked out and the block still owes, oldest first.
  replacer_reply_t replies_owed[$];

  // Predictor state: the evictable frames oldest first, their presence bits, and the
  // capacity as the block should currently see it.
  logic [lfr_pkg::ID_W-1:0]  lru_order[$];
  bit                        held_map[lfr_pkg::ID_SPACE];
  logic [lfr_pkg::CAP_W-1:0] cap_shadow = lfr_pkg::CAP_RESET;

  int  cycle_count = 0;
  int  fault_count = 0;
  int  reply_index = 0;
  int  req_total = 0;
  int  hold_left = 0;
  int  stall_left = 0;
  bit  script_done = 1'b0;

  lru_frame_replacer_unit #(
    .NUM_FRAMES(NUM_FRAMES)
  ) uut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .capacity    (capacity),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .page_frame  (page_frame),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .victim_found(victim_found),
    .victim_frame(victim_frame),
    .entry_count (entry_count)
  );

  always #1 clk = ~clk;

  // Applies one request to the predictor state and returns the reply the block must give.
  // Unpin never refreshes recency: a frame already held keeps its place in the order.
  // A capacity above the frame count saturates at the frame count, and a capacity below the
  // current count leaves held frames alone while refusing further unpins.
  function automatic replacer_reply_t lru_apply(logic [1:0] op, logic [lfr_pkg::ID_W-1:0] fid);
    replacer_reply_t reply;
    int limit;
    int idx;
    reply = '0;
    limit = (int'(cap_shadow) < NUM_FRAMES) ? int'(cap_shadow) : NUM_FRAMES;
    case (op)
      lfr_pkg::OP_VICTIM: begin
        if (lru_order.size() > 0) begin
          reply.found = 1'b1;
          reply.frame = lru_order.pop_front();
          held_map[reply.frame] = 1'b0;
        end
      end
      lfr_pkg::OP_PIN: begin
        if (held_map[fid]) begin
          for (idx = 0; idx < lru_order.size(); idx++) begin
            if (lru_order[idx] == fid) begin
              lru_order.delete(idx);
              break;
            end
          end
          held_map[fid] = 1'b0;
        end
      end
      lfr_pkg::OP_UNPIN: begin
        if (!held_map[fid] && lru_order.size() < limit) begin
          lru_order.push_back(fid);
          held_map[fid] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    reply.count = lfr_pkg::COUNT_OUT_W'(lru_order.size());
    return reply;
  endfunction

  // Idle length for either side. Most gaps are short and a few are long; every so often a
  // calm stretch runs with no idling at all so that back-to-back traffic is exercised too.
  function automatic int next_gap();
    int roll;
    if ((cycle_count % 4000) < 800) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_request(logic [1:0] op, logic [lfr_pkg::ID_W-1:0] fid);
    script_step_t step;
    step = '0;
    step.kind = STEP_REQUEST;
    step.op = op;
    step.fid = fid;
    request_script.push_back(step);
    req_total++;
  endtask

  task automatic add_capacity(logic [lfr_pkg::CAP_W-1:0] cap);
    script_step_t step;
    step = '0;
    step.kind = STEP_CAPACITY;
    step.cap = cap;
    request_script.push_back(step);
  endtask

  task automatic add_quiesce();
    script_step_t step;
    step = '0;
    step.kind = STEP_QUIESCE;
    request_script.push_back(step);
  endtask

  task automatic note_fault(string msg);
    fault_count++;
    if (fault_count <= REPORT_MAX) $display("%s", msg);
  endtask

  // Capacity choices for the random phases: both extremes, the reset value, the smallest
  // nonzero limit, and random values on either side of the frame count.
  function automatic logic [lfr_pkg::CAP_W-1:0] pick_capacity();
    case ($urandom_range(0, 5))
      0: return lfr_pkg::CAP_W'(0);
      1: return lfr_pkg::CAP_W'(1);
      2: return lfr_pkg::CAP_W'(NUM_FRAMES);
      3: return lfr_pkg::CAP_W'(127);
      4: return lfr_pkg::CAP_W'($urandom_range(2, NUM_FRAMES - 1));
      default: return lfr_pkg::CAP_W'($urandom_range(NUM_FRAMES + 1, 126));
    endcase
  endfunction

  // Request driver. Predictions are made at the edge where a request is accepted, so the
  // owed-reply queue always matches what the block has taken in. Capacity writes and quiesce
  // steps wait until every owed reply has arrived, which leaves the block idle.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      cfg_valid <= 1'b0;
      hold_left = 0;
    end else begin
      if (in_valid && in_ready) replies_owed.push_back(lru_apply(opcode, page_frame));
      if (cfg_valid && cfg_ready) cap_shadow = capacity;

      if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
        // A request or a write is still on offer; keep it steady.
      end else if (hold_left > 0) begin
        hold_left--;
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end else if (request_script.size() == 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        script_done = 1'b1;
      end else begin
        case (request_script[0].kind)
          STEP_REQUEST: begin
            in_valid <= 1'b1;
            opcode <= request_script[0].op;
            page_frame <= request_script[0].fid;
            cfg_valid <= 1'b0;
            void'(request_script.pop_front());
            hold_left = next_gap();
          end
          STEP_CAPACITY: begin
            in_valid <= 1'b0;
            if (replies_owed.size() == 0) begin
              cfg_valid <= 1'b1;
              capacity <= request_script[0].cap;
              void'(request_script.pop_front());
            end else begin
              cfg_valid <= 1'b0;
            end
          end
          default: begin
            in_valid <= 1'b0;
            cfg_valid <= 1'b0;
            if (replies_owed.size() == 0) begin
              void'(request_script.pop_front());
              hold_left = next_gap();
            end
          end
        endcase
      end
    end
  end

  // Reply monitor. Every reply taken is matched against the oldest owed one, field by field.
  // After each reply the receiver may stall for a random while.
  always @(posedge clk) begin
    replacer_reply_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (replies_owed.size() == 0) begin
          note_fault($sformatf("reply %0d arrived with none owed: found=%0b frame=%0d count=%0d",
                               reply_index, victim_found, victim_frame, entry_count));
        end else begin
          want = replies_owed.pop_front();
          if (victim_found !== want.found || victim_frame !== want.frame ||
              entry_count !== want.count) begin
            note_fault($sformatf({"reply %0d: expected found=%0b frame=%0d count=%0d, ",
                                  "got found=%0b frame=%0d count=%0d"},
                                 reply_index, want.found, want.frame, want.count,
                                 victim_found, victim_frame, entry_count));
          end
        end
        reply_index++;
        stall_left = next_gap();
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: a hung handshake or a missing reply ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    logic [lfr_pkg::ID_W-1:0] sweep[NUM_FRAMES];
    logic [lfr_pkg::ID_W-1:0] swap;
    int seg_len;
    int unpin_pct;
    int pin_pct;
    int roll;
    int narrow;
    int k;
    int j;

    // Directed part, starting from the reset capacity of 64.
    add_request(lfr_pkg::OP_VICTIM, 6'h3F);  // victim on an empty list reports none
    add_request(lfr_pkg::OP_PIN, 6'd5);      // pin of a frame that is not held
    add_request(OP_RESERVED, 6'h3F);         // unassigned opcode changes nothing
    add_request(lfr_pkg::OP_UNPIN, 6'd0);
    add_request(lfr_pkg::OP_UNPIN, 6'h3F);
    add_request(lfr_pkg::OP_UNPIN, 6'd0);    // already held: no change, no recency refresh
    add_request(lfr_pkg::OP_UNPIN, 6'd21);
    add_request(lfr_pkg::OP_UNPIN, 6'd42);
    add_request(lfr_pkg::OP_PIN, 6'h3F);     // removal from the middle closes the gap
    add_request(lfr_pkg::OP_PIN, 6'h3F);     // now absent
    add_request(lfr_pkg::OP_VICTIM, 6'd0);   // oldest frame 0 leaves
    add_request(OP_RESERVED, 6'd42);
    add_request(lfr_pkg::OP_UNPIN, 6'd0);    // list is now 21, 42, 0

    // Capacity dropped below the current count: held frames stay, unpins are refused.
    add_capacity(lfr_pkg::CAP_W'(2));
    add_request(lfr_pkg::OP_UNPIN, 6'd5);
    add_request(lfr_pkg::OP_PIN, 6'd21);
    add_request(lfr_pkg::OP_UNPIN, 6'd5);    // count equals capacity, still refused
    add_request(lfr_pkg::OP_VICTIM, 6'd0);
    add_request(lfr_pkg::OP_UNPIN, 6'd5);    // room again
    add_request(lfr_pkg::OP_UNPIN, 6'd7);

    // Zero capacity refuses every unpin while the list drains to empty.
    add_capacity(lfr_pkg::CAP_W'(0));
    add_request(lfr_pkg::OP_UNPIN, 6'd9);
    add_request(lfr_pkg::OP_VICTIM, 6'd0);
    add_request(lfr_pkg::OP_VICTIM, 6'd0);
    add_request(lfr_pkg::OP_VICTIM, 6'd0);

    // Largest register value: the limit saturates at the frame count.
    add_capacity(lfr_pkg::CAP_W'(127));

    // Random part: full sweeps that fill the list in a shuffled order, churn segments with
    // their own opcode mix, capacity changes and quiet points between them.
    while (req_total < RUN_REQUESTS) begin
      case ($urandom_range(0, 7))
        0: add_capacity(pick_capacity());
        1: add_quiesce();
        2: begin
          for (k = 0; k < NUM_FRAMES; k++) sweep[k] = lfr_pkg::ID_W'(k);
          for (k = NUM_FRAMES - 1; k > 0; k--) begin
            j = $urandom_range(0, k);
            swap = sweep[k];
            sweep[k] = sweep[j];
            sweep[j] = swap;
          end
          for (k = 0; k < NUM_FRAMES; k++) add_request(lfr_pkg::OP_UNPIN, sweep[k]);
        end
        default: begin
          seg_len = $urandom_range(20, 60);
          unpin_pct = $urandom_range(20, 70);
          pin_pct = $urandom_range(10, 40);
          narrow = $urandom_range(0, 1);
          for (k = 0; k < seg_len; k++) begin
            roll = $urandom_range(0, 99);
            // A narrow id range makes pins and duplicate unpins hit held frames often.
            j = narrow ? $urandom_range(0, 7) : $urandom_range(0, NUM_FRAMES - 1);
            if (roll < 5) add_request(OP_RESERVED, lfr_pkg::ID_W'(j));
            else if (roll < 5 + unpin_pct) add_request(lfr_pkg::OP_UNPIN, lfr_pkg::ID_W'(j));
            else if (roll < 5 + unpin_pct + pin_pct) begin
              add_request(lfr_pkg::OP_PIN, lfr_pkg::ID_W'(j));
            end
            else add_request(lfr_pkg::OP_VICTIM, lfr_pkg::ID_W'(j));
          end
        end
      endcase
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (!script_done) @(posedge clk);
    while (replies_owed.size() != 0) @(posedge clk);
    // Give a stray extra reply time to show up before the verdict.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/lfr_pkg.sv
rtl/lfr_order_mem.sv
rtl/lru_frame_replacer_unit.sv
tb/sv/tb_lru_frame_replacer_unit.sv
